// ===== src/tsbw_pkg.sv =====
`default_nettype none

package tsbw_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUR_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOCUS_CENTER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FOCUS_WIDTH  = 2'd2;

    // Quotient bits resolved in each divider stage
    localparam int DIV_BITS_PER_STAGE = 2;

    // Control flags that travel with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic zero;   // weight forced to zero (disabled, invalid or inside band)
        logic sat;    // distance past the edge reaches the span: t clamps to 1.0
    } tsbw_ctl_t;

endpackage

`default_nettype wire

// ===== src/tilt_shift_blur_weight.sv =====
`default_nettype none

// Channel   Signals                                   Direction
// config    cfg_write_en, cfg_index, cfg_data          in (write only)
// input     in_valid/in_ready, row_position,           in
//           position_invalid
// output    out_valid/out_ready, blur_weight           out
//
// One item enters per cycle while the output is not stalled. The pipeline has
// three setup stages, the divider stages and two multiply stages.
// The divider, two quotient bits per stage, sets the pipeline depth.
// Reset clears the configuration registers and all valid flags.
// A stall on the output freezes the whole pipeline; bubbles drain while
// the output register is empty.
module tilt_shift_blur_weight
    import tsbw_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [FRAC_BITS+1:0]        cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [FRAC_BITS+1:0] row_position,
    input  wire logic                        position_invalid,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [FRAC_BITS:0]               blur_weight
);

    localparam int F       = FRAC_BITS;
    localparam int EPS_RAW = ((1 << F) + 5000) / 10000;
    localparam logic [F:0]   ONE   = {1'b1, {F{1'b0}}};
    localparam logic [F-1:0] HALF  = {1'b1, {(F-1){1'b0}}};
    localparam logic [F+1:0] THREE = {2'b11, {F{1'b0}}};
    localparam logic [F:0]   EPS   = (F+1)'((EPS_RAW < 1) ? 1 : EPS_RAW);

    // Configuration registers
    logic         enable_reg;
    logic [F:0]   center_reg;
    logic [F+1:0] width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            center_reg <= '0;
            width_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_BLUR_ENABLE:  enable_reg <= cfg_data[0];
                REG_FOCUS_CENTER: center_reg <= cfg_data[F:0];
                REG_FOCUS_WIDTH:  width_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Pipeline registers
    tsbw_ctl_t    ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    tsbw_ctl_t    ctl1_next, ctl3_next;
    logic [F:0]   y1_reg, y1_next;
    logic [F-1:0] hw1_reg, hw1_next, hw2_reg;
    logic [F:0]   d2_reg, d2_next, span2_reg, span2_next;
    logic [F:0]   num3_reg, num3_next, span3_reg;
    logic [F:0]   t4_reg, t4_next, t2_4_reg, t2_4_next;
    logic [F:0]   w5_reg, w5_next;
    tsbw_ctl_t    div_ctl;
    logic [F-1:0] div_quo;
    logic         adv;

    // Whole pipeline moves unless the output holds an untaken result
    assign adv      = !ctl5_reg.valid || out_ready;
    assign in_ready = adv;

    // Stage 1: clamp position and half width, flag disabled or invalid
    always_comb
    begin : stage1_calc
        logic [F:0] hw_full;
        hw_full         = width_reg[F+1:1];
        ctl1_next.valid = in_valid;
        ctl1_next.zero  = !enable_reg || position_invalid;
        ctl1_next.sat   = 1'b0;
        if (row_position[F+1])
            y1_next = '0;
        else if (row_position[F:0] > ONE)
            y1_next = ONE;
        else
            y1_next = row_position[F:0];
        if (hw_full > {1'b0, HALF})
            hw1_next = HALF;
        else
            hw1_next = hw_full[F-1:0];
    end

    // Stage 2: distance to center and span on the larger side
    always_comb
    begin : stage2_calc
        logic [F:0] side;
        logic [F:0] span_raw;
        if (y1_reg >= center_reg)
            d2_next = y1_reg - center_reg;
        else
            d2_next = center_reg - y1_reg;
        if (center_reg > {1'b0, HALF})
            side = center_reg;
        else
            side = ONE - center_reg;
        span_raw = side - {1'b0, hw1_reg};
        if (span_raw < EPS)
            span2_next = EPS;
        else
            span2_next = span_raw;
    end

    // Stage 3: distance past the band edge, inside and saturation flags
    always_comb
    begin
        num3_next       = d2_reg - {1'b0, hw2_reg};
        ctl3_next.valid = ctl2_reg.valid;
        ctl3_next.zero  = ctl2_reg.zero || (d2_reg <= {1'b0, hw2_reg});
        ctl3_next.sat   = (num3_next >= span2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl3_next;
            ctl4_reg <= div_ctl;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y1_reg    <= y1_next;
            hw1_reg   <= hw1_next;
            d2_reg    <= d2_next;
            span2_reg <= span2_next;
            hw2_reg   <= hw1_reg;
            num3_reg  <= num3_next;
            span3_reg <= span2_reg;
            t4_reg    <= t4_next;
            t2_4_reg  <= t2_4_next;
            w5_reg    <= w5_next;
        end
    end

    // Fraction of the span covered, one quotient bit pair per stage
    tsbw_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_ctl  (ctl3_reg),
        .num     (num3_reg),
        .span    (span3_reg),
        .out_ctl (div_ctl),
        .quo     (div_quo)
    );

    // Stage 4: clamp t and square it
    always_comb
    begin : stage4_calc
        logic [2*F+1:0] sq;
        t4_next   = div_ctl.sat ? ONE : {1'b0, div_quo};
        sq        = (2*F+2)'(t4_next) * (2*F+2)'(t4_next);
        t2_4_next = sq[2*F:F];
    end

    // Stage 5: smoothstep t2 * (3 - 2t), clamp, force zero
    always_comb
    begin : stage5_calc
        logic [F+1:0]   k;
        logic [2*F+2:0] prod;
        logic [F+2:0]   w_full;
        k      = THREE - {t4_reg, 1'b0};
        prod   = (2*F+3)'(t2_4_reg) * (2*F+3)'(k);
        w_full = prod[2*F+2:F];
        if (ctl4_reg.zero)
            w5_next = '0;
        else if (w_full > {2'b00, ONE})
            w5_next = ONE;
        else
            w5_next = w_full[F:0];
    end

    assign out_valid   = ctl5_reg.valid;
    assign blur_weight = w5_reg;

    // Weight never exceeds 1.0
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (blur_weight <= ONE))
        else $error("blur weight above one");

    // Square of a clamped t stays within 1.0
    a_square_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl4_reg.valid |-> (t2_4_reg <= ONE && t4_reg <= ONE))
        else $error("t or t squared above one");

    // A held result keeps its value through a stall
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> (out_valid && $stable(blur_weight)))
        else $error("result changed during stall");

endmodule

`default_nettype wire

// ===== src/tsbw_div.sv =====
`default_nettype none

// Pipelined restoring divider: quo = (num << FRAC_BITS) / span for num < span.
// Resolves DIV_BITS_PER_STAGE quotient bits per register stage.
module tsbw_div
    import tsbw_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire tsbw_ctl_t            in_ctl,
    input  wire logic [FRAC_BITS:0]   num,
    input  wire logic [FRAC_BITS:0]   span,
    output tsbw_ctl_t                 out_ctl,
    output logic [FRAC_BITS-1:0]      quo
);

    localparam int F      = FRAC_BITS;
    localparam int BPS    = DIV_BITS_PER_STAGE;
    localparam int STAGES = (F + BPS - 1) / BPS;

    tsbw_ctl_t        ctl_reg [STAGES];
    logic [F:0]       rem_reg [STAGES];
    logic [F:0]       den_reg [STAGES];
    logic [F-1:0]     quo_reg [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            tsbw_ctl_t    ctl_prev;
            logic [F:0]   rem_prev;
            logic [F:0]   den_prev;
            logic [F-1:0] quo_prev;
            logic [F:0]   rem_next;
            logic [F-1:0] quo_next;

            // Select the previous stage, or the ports for the first stage
            if (s == 0)
            begin : g_first
                assign ctl_prev = in_ctl;
                assign rem_prev = num;
                assign den_prev = span;
                assign quo_prev = '0;
            end
            else
            begin : g_next
                assign ctl_prev = ctl_reg[s-1];
                assign rem_prev = rem_reg[s-1];
                assign den_prev = den_reg[s-1];
                assign quo_prev = quo_reg[s-1];
            end

            // Shift, trial subtract, shift in one quotient bit per step
            always_comb
            begin : step_calc
                logic [F+1:0] dbl;
                rem_next = rem_prev;
                quo_next = quo_prev;
                dbl      = '0;
                for (int k = 0; k < BPS; k++)
                begin
                    if (s * BPS + k < F)
                    begin
                        dbl = {rem_next, 1'b0};
                        if (dbl >= {1'b0, den_prev})
                        begin
                            dbl      = dbl - {1'b0, den_prev};
                            quo_next = {quo_next[F-2:0], 1'b1};
                        end
                        else
                        begin
                            quo_next = {quo_next[F-2:0], 1'b0};
                        end
                        rem_next = dbl[F:0];
                    end
                end
            end

            // Advance control flags
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    ctl_reg[s] <= '0;
                end
                else if (en)
                begin
                    ctl_reg[s] <= ctl_prev;
                end
            end

            // Advance payload
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_prev;
                    quo_reg[s] <= quo_next;
                end
            end
        end
    endgenerate

    assign out_ctl = ctl_reg[STAGES-1];
    assign quo     = quo_reg[STAGES-1];

endmodule

`default_nettype wire

// ===== sim/blur_weight_checker.sv =====
module blur_weight_checker
    import tsbw_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [FRAC_BITS+1:0]        cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [FRAC_BITS+1:0] row_position,
    input  logic                        position_invalid,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [FRAC_BITS:0]          blur_weight,
    output int                          weights_pending,
    output int                          mismatch_count
);

    localparam longint UNITY = longint'(1) << FRAC_BITS;
    localparam longint FLOOR_ROUNDED = (UNITY + 5000) / 10000;
    localparam longint SPAN_FLOOR = (FLOOR_ROUNDED < 1) ? 1 : FLOOR_ROUNDED;

    // Shadow copy of the configuration registers
    logic                 enable_q;
    logic [FRAC_BITS:0]   center_q;
    logic [FRAC_BITS+1:0] width_q;

    // Weights predicted for accepted rows, oldest first
    logic [FRAC_BITS:0] expected_weights[$];

    // Smoothstep falloff of one row against the current band setting
    function automatic logic [FRAC_BITS:0] blur_weight_of(
        input logic signed [FRAC_BITS+1:0] pos,
        input logic                        invalid
    );
        longint y;
        longint c;
        longint half;
        longint gap;
        longint span;
        longint t;
        longint t_sq;
        longint w;
        if (!enable_q || invalid)
        begin
            return '0;
        end
        y = longint'(pos);
        if (y < 0)
            y = 0;
        if (y > UNITY)
            y = UNITY;
        c = longint'(center_q);
        half = longint'(width_q >> 1);
        if (half > UNITY / 2)
            half = UNITY / 2;
        gap = (y > c) ? y - c : c - y;
        // on the band edge still counts as sharp
        if (gap <= half)
        begin
            return '0;
        end
        span = ((c > UNITY - c) ? c : UNITY - c) - half;
        if (span < SPAN_FLOOR)
            span = SPAN_FLOOR;
        t = ((gap - half) << FRAC_BITS) / span;
        if (t > UNITY)
            t = UNITY;
        t_sq = (t * t) >> FRAC_BITS;
        w = (t_sq * (3 * UNITY - 2 * t)) >> FRAC_BITS;
        if (w > UNITY)
            w = UNITY;
        return w[FRAC_BITS:0];
    endfunction

    // Track config writes, predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_q <= 1'b0;
            center_q <= '0;
            width_q <= '0;
            expected_weights.delete();
            weights_pending <= 0;
            mismatch_count <= 0;
        end
        else
        begin : track
            logic [FRAC_BITS:0] want;
            int delta;
            delta = 0;
            // compare before queuing so a stray result cannot match a fresh row
            if (out_valid && out_ready)
            begin
                if (expected_weights.size() == 0)
                begin
                    $error("blur_weight: unexpected result, actual %0d", blur_weight);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_weights.pop_front();
                    delta = delta - 1;
                    if (blur_weight !== want)
                    begin
                        $error("blur_weight: expected %0d, actual %0d", want, blur_weight);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_weights.push_back(blur_weight_of(row_position, position_invalid));
                delta = delta + 1;
            end
            weights_pending <= weights_pending + delta;
            // drop writes to unknown indexes
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_BLUR_ENABLE:  enable_q <= cfg_data[0];
                    REG_FOCUS_CENTER: center_q <= cfg_data[FRAC_BITS:0];
                    REG_FOCUS_WIDTH:  width_q <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sim/tilt_shift_blur_weight_tb.sv =====
module tilt_shift_blur_weight_tb;
    import tsbw_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int LATENCY = 5 + (FRAC_BITS + 1) / 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PERCENT = 34;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int PHASE_ITEMS = 166;
    localparam int PHASE_COUNT = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_write_en;
    logic [CFG_INDEX_W-1:0]      cfg_index;
    logic [FRAC_BITS+1:0]        cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [FRAC_BITS+1:0] row_position;
    logic                        position_invalid;
    logic                        out_valid;
    logic                        out_ready;
    logic [FRAC_BITS:0]          blur_weight;

    int weights_pending;
    int mismatch_count;
    int cycle_count = 0;
    bit idle_enable = 1'b1;
    bit hold_request = 1'b0;
    int cur_center;
    int cur_half;

    tilt_shift_blur_weight #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .row_position     (row_position),
        .position_invalid (position_invalid),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .blur_weight      (blur_weight)
    );

    blur_weight_checker #(.FRAC_BITS(FRAC_BITS)) weight_monitor (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .row_position     (row_position),
        .position_invalid (position_invalid),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .blur_weight      (blur_weight),
        .weights_pending  (weights_pending),
        .mismatch_count   (mismatch_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int hold_count;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_OFF_CYCLES)
                begin
                    @(posedge clk);
                    hold_count++;
                end
            end
            else if (idle_enable)
            begin
                out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one row and hold it until the transfer
    task automatic send_row(input int pos, input logic invalid);
        while (idle_enable && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        row_position <= pos[FRAC_BITS+1:0];
        position_invalid <= invalid;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every weight is back
    task automatic drain_weights();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (weights_pending != 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Write all registers, plus one write to an unused index
    task automatic set_band(
        input logic enable,
        input int   center,
        input int   width
    );
        cfg_write_en <= 1'b1;
        cfg_index <= REG_BLUR_ENABLE;
        cfg_data <= {{(FRAC_BITS+1){1'b0}}, enable};
        @(posedge clk);
        cfg_index <= REG_FOCUS_CENTER;
        cfg_data <= {1'b0, center[FRAC_BITS:0]};
        @(posedge clk);
        cfg_index <= REG_FOCUS_WIDTH;
        cfg_data <= width[FRAC_BITS+1:0];
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data <= (FRAC_BITS+2)'($urandom);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_center = int'(center[FRAC_BITS:0]);
        cur_half = int'(width[FRAC_BITS+1:1]);
        if (cur_half > ONE / 2)
            cur_half = ONE / 2;
    endtask

    // Mostly in-range rows, some full-range noise, some hugging the band edges
    task automatic run_random_phase(input int count, input bit hold_mid, input bit pause_mid);
        int k;
        int sel;
        int edge_pos;
        int pos;
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(99);
            if (sel < 60)
            begin
                pos = int'($urandom_range(ONE, 0));
            end
            else if (sel < 80)
            begin
                pos = int'($urandom);
            end
            else
            begin
                edge_pos = cur_center + ($urandom_range(1) ? cur_half : -cur_half)
                           + int'($urandom_range(8)) - 4;
                pos = edge_pos;
            end
            if (hold_mid && k == count / 3)
                hold_request = 1'b1;
            if (pause_mid && k == count / 2)
                drain_weights();
            send_row(pos, $urandom_range(99) < 10);
        end
    endtask

    initial
    begin : stimulus
        int phase;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = REG_BLUR_ENABLE;
        cfg_data = '0;
        in_valid = 1'b0;
        row_position = '0;
        position_invalid = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Band in the middle: clamps, center, both edges and just past them
        set_band(1'b1, ONE / 2, ONE / 4);
        send_row(-131072, 1'b0);
        send_row(131071, 1'b0);
        send_row(0, 1'b0);
        send_row(ONE, 1'b0);
        send_row(-1, 1'b0);
        send_row(ONE - 1, 1'b0);
        send_row(ONE / 2, 1'b0);
        send_row(ONE / 2 - ONE / 8, 1'b0);
        send_row(ONE / 2 + ONE / 8, 1'b0);
        send_row(ONE / 2 - ONE / 8 - 1, 1'b0);
        send_row(ONE / 2 + ONE / 8 + 1, 1'b0);
        send_row(100000, 1'b1);

        // Disabled
        drain_weights();
        set_band(1'b0, ONE, 2 * ONE);
        send_row(0, 1'b0);
        send_row(ONE, 1'b0);

        // Center above one, width clamped
        drain_weights();
        set_band(1'b1, (1 << (FRAC_BITS + 1)) - 1, (1 << (FRAC_BITS + 2)) - 1);
        send_row(0, 1'b0);
        send_row(ONE, 1'b0);
        send_row(-131072, 1'b1);

        // Span below the floor
        drain_weights();
        set_band(1'b1, ONE / 2 + 2, ONE);
        send_row(0, 1'b0);
        send_row(ONE, 1'b0);
        send_row(1, 1'b0);

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_weights();
            idle_enable = (phase != 2);
            case (phase)
                0: set_band(1'b1, $urandom_range(ONE, 0), $urandom_range(2 * ONE, 0));
                1: set_band(1'b1, 0, 0);
                2: set_band(1'b1, ONE, 0);
                3: set_band(1'b0, $urandom_range(ONE, 0), $urandom_range(2 * ONE, 0));
                4: set_band(1'b1, (1 << (FRAC_BITS + 1)) - 1, (1 << (FRAC_BITS + 2)) - 1);
                5: set_band(1'b1, ONE / 2 + int'($urandom_range(8)), ONE);
                6: set_band(1'b1, int'($urandom), int'($urandom));
                default: set_band(1'b1, $urandom_range(ONE, 0), $urandom_range(ONE / 4, 0));
            endcase
            run_random_phase(PHASE_ITEMS, phase == 0, phase == 1);
        end

        drain_weights();
        if (mismatch_count == 0 && weights_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
